@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every rising edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Condition must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

@@ rtl/core/crc64bs_pkg.sv @@
// Types, constants and CRC helpers for the CRC-64 byte stream checker.
package crc64bs_pkg;

    localparam int LENGTH_BITS_DEFAULT = 32;
    localparam int PAYLOAD_LEN_BITS    = 32;
    localparam int CRC_BITS            = 64;
    localparam int QUEUE_DEPTH         = 2;
    localparam int QUEUE_PTR_BITS      = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_INDEX_BITS      = 2;
    localparam int WINDOW_BYTES        = 8;

    localparam logic [CRC_BITS-1:0] CRC_POLY  = 64'h95ac9329ac4bc9b5;
    localparam logic [7:0]          BYTE_MASK = 8'hff;

    typedef enum logic [1:0] {
        STATUS_COMPUTED  = 2'd0,
        STATUS_MATCH     = 2'd1,
        STATUS_MISMATCH  = 2'd2,
        STATUS_TOO_SHORT = 2'd3
    } status_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_START_VALUE   = 2'd0,
        CFG_CHECK_MODE    = 2'd1,
        CFG_TRAILER_BIG   = 2'd2,
        CFG_UNUSED        = 2'd3
    } cfg_index_t;

    typedef logic [CRC_BITS-1:0] crc_table_t [256];

    // One classified byte handed from the front end to the CRC engine.
    typedef struct packed {
        logic                        first;      // load start value before folding
        logic                        fold_en;    // fold fold_byte into the CRC
        logic [7:0]                  fold_byte;
        logic                        last;       // emit a result after this item
        logic                        compare;    // result status comes from trailer compare
        status_t                     status;     // status when no compare is needed
        logic [PAYLOAD_LEN_BITS-1:0] length;
        logic [CRC_BITS-1:0]         stored;     // trailer CRC, already in register order
    } entry_t;

    function automatic crc_table_t gen_crc_table();
        crc_table_t          tbl;
        logic [CRC_BITS-1:0] c;
        for (int i = 0; i < 256; i++) begin
            c = CRC_BITS'(i);
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            tbl[i] = c;
        end
        return tbl;
    endfunction

    localparam crc_table_t CRC_TABLE = gen_crc_table();

    // Reflected byte step: one table lookup and two xors.
    function automatic logic [CRC_BITS-1:0] crc_step(input logic [CRC_BITS-1:0] crc,
                                                     input logic [7:0] b);
        logic [7:0] idx;
        idx = (crc[7:0] ^ b) & BYTE_MASK;
        return (crc >> 8) ^ CRC_TABLE[idx];
    endfunction

    function automatic logic [CRC_BITS-1:0] swap_bytes(input logic [CRC_BITS-1:0] v);
        logic [CRC_BITS-1:0] r;
        for (int i = 0; i < WINDOW_BYTES; i++) begin
            r[8*i +: 8] = v[8*(WINDOW_BYTES-1-i) +: 8];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/crc64bs_front.sv @@
// Front end: accepts bytes, tracks trailer window and length, classifies each item.
module crc64bs_front import crc64bs_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] data_byte
    input  logic        s_tlast,
    input  logic        check_mode,
    input  logic        trailer_big_endian,
    input  logic        q_full,
    output logic        q_push,
    output entry_t      q_entry
);

    logic                       in_msg_reg;
    logic [CRC_BITS-1:0]        window_reg, window_next, window_base;
    logic [3:0]                 fill_reg, fill_next, fill_base;
    logic [LENGTH_BITS-1:0]     count_reg, count_next, count_base;
    logic                       count_inc;
    logic                       fold_en;
    logic [7:0]                 fold_sel;
    logic [PAYLOAD_LEN_BITS-1:0] len_sat;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    always_comb begin
        window_base = in_msg_reg ? window_reg : '0;
        fill_base   = in_msg_reg ? fill_reg : '0;
        count_base  = in_msg_reg ? count_reg : '0;
        window_next = window_base;
        fill_next   = fill_base;
        count_inc   = 1'b0;
        fold_en     = 1'b0;
        fold_sel    = s_tdata;
        if (check_mode) begin
            if (fill_base >= 4'(WINDOW_BYTES)) begin
                fold_en   = 1'b1;
                fold_sel  = window_base[CRC_BITS-1 -: 8];
                count_inc = 1'b1;
            end else begin
                fill_next = fill_base + 4'd1;
            end
            window_next = {window_base[CRC_BITS-9:0], s_tdata};
        end else begin
            fold_en   = 1'b1;
            count_inc = 1'b1;
        end
        count_next = (count_inc && (count_base != '1)) ? count_base + 1'b1 : count_base;
    end

    generate
        if (LENGTH_BITS > PAYLOAD_LEN_BITS) begin : g_len_wide
            assign len_sat = (|count_next[LENGTH_BITS-1:PAYLOAD_LEN_BITS]) ?
                             '1 : count_next[PAYLOAD_LEN_BITS-1:0];
        end else begin : g_len_narrow
            assign len_sat = PAYLOAD_LEN_BITS'(count_next);
        end
    endgenerate

    always_comb begin
        q_entry.first     = !in_msg_reg;
        q_entry.fold_en   = fold_en;
        q_entry.fold_byte = fold_sel;
        q_entry.last      = s_tlast;
        q_entry.stored    = trailer_big_endian ? window_next : swap_bytes(window_next);
        q_entry.compare   = 1'b0;
        q_entry.status    = STATUS_COMPUTED;
        q_entry.length    = len_sat;
        if (check_mode) begin
            if (fill_next < 4'(WINDOW_BYTES)) begin
                q_entry.status = STATUS_TOO_SHORT;
                q_entry.length = '0;
            end else begin
                q_entry.compare = 1'b1;
                q_entry.status  = STATUS_MATCH;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_msg_reg <= 1'b0;
        end else if (q_push) begin
            in_msg_reg <= !s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_push) begin
            window_reg <= window_next;
            fill_reg   <= fill_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/core/crc64bs_queue.sv @@
// Two-entry queue of classified items between front end and CRC engine.
module crc64bs_queue import crc64bs_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   valid,
    output entry_t head
);

    entry_t                    slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_BITS-1:0] count_reg, count_next;

    assign full  = (count_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ rtl/core/crc64bs_back.sv @@
// CRC engine: folds queued bytes, compares trailer, holds the result register.
module crc64bs_back import crc64bs_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    input  entry_t                 q_head,
    output logic                   q_pop,
    input  logic [CRC_BITS-1:0]    start_value,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [95:0]            m_tdata,   // [63:0] crc_value, [95:64] payload_length
    output logic [1:0]             m_tuser    // [1:0] status
);

    logic [CRC_BITS-1:0] crc_reg, crc_next, crc_base;
    logic                out_valid_reg;
    logic [95:0]         out_data_reg;
    status_t             out_status_reg, status_next;

    assign q_pop    = q_valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

    always_comb begin
        crc_base = q_head.first ? start_value : crc_reg;
        crc_next = q_head.fold_en ? crc_step(crc_base, q_head.fold_byte) : crc_base;
        if (q_head.compare) begin
            status_next = (q_head.stored == crc_next) ? STATUS_MATCH : STATUS_MISMATCH;
        end else begin
            status_next = q_head.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            crc_reg       <= '0;
        end else begin
            if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (q_pop) begin
                crc_reg <= crc_next;
                if (q_head.last) begin
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_head.last) begin
            out_status_reg <= status_next;
            if (q_head.status == STATUS_TOO_SHORT && !q_head.compare) begin
                out_data_reg <= '0;
            end else begin
                out_data_reg <= {q_head.length, crc_next};
            end
        end
    end

endmodule

@@ rtl/core/crc64_byte_stream_checker.sv @@
// Top level of the CRC-64 (reflected Jones) byte stream checker.
// One message byte per item on s_*, s_tlast marks the message end; one result
// per message on m_*. Throughput is one byte per clock: the front end takes a
// byte every cycle while the two-entry queue has room, and the CRC engine folds
// one byte per cycle, while its result register is empty or being taken, with a
// 256-entry table lookup and xor. The clock period is set by that lookup, xor
// and the 64-bit trailer compare in the engine. The last byte of a message passes
// through the queue and then the result register; the result is held until
// m_tready. In check mode the final eight bytes are the stored CRC (byte order
// per trailer_big_endian); too-short messages report status 3 with zero CRC and
// length. The CRC starts at start_value with no final xor; the byte count
// saturates at 2^LENGTH_BITS-1 and is reported clipped to 32 bits. Configuration
// writes (always ready) are meant for idle periods only.
`include "assert_macros.svh"

module crc64_byte_stream_checker import crc64bs_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // byte input
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,    // [7:0] data_byte
    input  logic                      s_tlast,    // last_byte
    // result output
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [95:0]               m_tdata,    // [63:0] crc_value, [95:64] payload_length
    output logic [1:0]                m_tuser,    // [1:0] status
    // configuration writes
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CRC_BITS-1:0]       cfg_data
);

    logic [CRC_BITS-1:0] start_value_reg;
    logic                check_mode_reg;
    logic                trailer_big_reg;

    logic   q_push, q_full, q_pop, q_valid;
    entry_t push_entry, head_entry;

    assign cfg_ready = 1'b1;

    // Register file; unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_value_reg <= '0;
            check_mode_reg  <= 1'b0;
            trailer_big_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_START_VALUE: start_value_reg <= cfg_data;
                CFG_CHECK_MODE:  check_mode_reg  <= cfg_data[0];
                CFG_TRAILER_BIG: trailer_big_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Front end: window, fill and length tracking, item classification.
    crc64bs_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_tvalid           (s_tvalid),
        .s_tready           (s_tready),
        .s_tdata            (s_tdata),
        .s_tlast            (s_tlast),
        .check_mode         (check_mode_reg),
        .trailer_big_endian (trailer_big_reg),
        .q_full             (q_full),
        .q_push             (q_push),
        .q_entry            (push_entry)
    );

    // Decouples the front end from the CRC engine.
    crc64bs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .head       (head_entry)
    );

    // CRC engine and result register.
    crc64bs_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_head      (head_entry),
        .q_pop       (q_pop),
        .start_value (start_value_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // Too-short results carry zero CRC and zero length.
    `ASSERT_AT(a_too_short_zero, aclk, aresetn, (m_tvalid && m_tuser == STATUS_TOO_SHORT) |-> (m_tdata == '0), "too-short result with nonzero payload")
    // Queue fills only through accepted items.
    `ASSERT_AT(a_ready_drop, aclk, aresetn, $fell(s_tready) |-> $past(q_push), "input stalled without a push")
    // The engine never pops an empty queue.
    `ASSERT_NEVER(a_pop_empty, aclk, aresetn, q_pop && !q_valid, "pop from empty queue")

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the CRC-64 byte stream checker, with a bitwise CRC predictor.
`timescale 1ns / 1ps

module tb;
    import crc64bs_pkg::*;

    // cycles to let the pipeline settle before a register write (queue, then result register)
    localparam int SETTLE_CYCLES = 4;
    // random bytes per idling phase
    localparam int PHASE_ITEMS   = 500;
    localparam int NUM_PHASES    = 4;
    // generous stop, far above the slowest legal run
    localparam int TIMEOUT_NS    = 5_000_000;

    // one result item as the block reports it
    typedef struct packed {
        logic [63:0] crc;
        logic [31:0] len;
        status_t     status;
    } crc_result_t;

    typedef enum bit {ROW_BYTE, ROW_CFG} row_kind_t;

    // directed row: a register write, or a byte repeated reps times (last on the final one)
    typedef struct packed {
        row_kind_t   kind;
        cfg_index_t  reg_idx;   // register rows only
        logic [63:0] value;     // register data, or the byte in [7:0]
        logic [7:0]  reps;
        logic        last;
        logic        typed;     // result typed in below instead of predicted
        crc_result_t want;
    } plan_row_t;

    localparam crc_result_t NONE     = '0;
    localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;
    localparam int          NUM_ROWS = 18;

    // Directed part. Byte rows carry CFG_UNUSED as a don't-care index.
    plan_row_t directed_plan [NUM_ROWS] = '{
        // right after reset: start 0, compute mode; CRC of a single zero byte is zero
        '{ROW_BYTE, CFG_UNUSED, 64'h00, 8'd1, 1'b1, 1'b1,
          '{64'h0, 32'd1, STATUS_COMPUTED}},
        '{ROW_BYTE, CFG_UNUSED, 64'hff, 8'd1, 1'b1, 1'b0, NONE},
        '{ROW_CFG, CFG_START_VALUE, ALL_ONES, 8'd0, 1'b0, 1'b0, NONE},
        // out-of-range index must be dropped
        '{ROW_CFG, CFG_UNUSED, 64'hdead_beef_0bad_f00d, 8'd0, 1'b0, 1'b0, NONE},
        '{ROW_BYTE, CFG_UNUSED, 64'h80, 8'd1, 1'b0, 1'b0, NONE},
        '{ROW_BYTE, CFG_UNUSED, 64'h01, 8'd1, 1'b1, 1'b0, NONE},
        // only bit 0 of the one-bit registers counts: check on, little endian
        '{ROW_CFG, CFG_CHECK_MODE, 64'h3, 8'd0, 1'b0, 1'b0, NONE},
        '{ROW_CFG, CFG_TRAILER_BIG, 64'h2, 8'd0, 1'b0, 1'b0, NONE},
        // too short for a trailer
        '{ROW_BYTE, CFG_UNUSED, 64'hff, 8'd1, 1'b1, 1'b1,
          '{64'h0, 32'd0, STATUS_TOO_SHORT}},
        // empty payload, zero trailer, start 0 -> match
        '{ROW_CFG, CFG_START_VALUE, 64'h0, 8'd0, 1'b0, 1'b0, NONE},
        '{ROW_BYTE, CFG_UNUSED, 64'h00, 8'd8, 1'b1, 1'b1,
          '{64'h0, 32'd0, STATUS_MATCH}},
        // empty payload, zero trailer, start all ones, big endian -> mismatch
        '{ROW_CFG, CFG_START_VALUE, ALL_ONES, 8'd0, 1'b0, 1'b0, NONE},
        '{ROW_CFG, CFG_TRAILER_BIG, 64'h1, 8'd0, 1'b0, 1'b0, NONE},
        '{ROW_BYTE, CFG_UNUSED, 64'h00, 8'd8, 1'b1, 1'b1,
          '{ALL_ONES, 32'd0, STATUS_MISMATCH}},
        // mode switch inside a message: window bytes are dropped, new start not used yet
        '{ROW_BYTE, CFG_UNUSED, 64'ha5, 8'd3, 1'b0, 1'b0, NONE},
        '{ROW_CFG, CFG_CHECK_MODE, 64'h0, 8'd0, 1'b0, 1'b0, NONE},
        '{ROW_CFG, CFG_START_VALUE, 64'h0, 8'd0, 1'b0, 1'b0, NONE},
        '{ROW_BYTE, CFG_UNUSED, 64'h3c, 8'd1, 1'b1, 1'b0, NONE}
    };

    // DUT signals; every input starts known
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [95:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = CFG_START_VALUE;
    logic [63:0] cfg_data  = 64'h0;

    // idling knobs, percent of cycles
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int fail_count     = 0;

    // predictor: register copy and message state, reset values as the block
    logic [63:0] ex_start   = 64'h0;
    logic        ex_check   = 1'b0;
    logic        ex_big     = 1'b0;
    logic [63:0] crc_acc    = 64'h0;
    logic [63:0] trail_win  = 64'h0;   // newest byte in [7:0]
    logic [3:0]  trail_fill = 4'd0;
    logic [31:0] byte_total = 32'd0;   // LENGTH_BITS = 32, so no clipping on report
    logic        msg_open   = 1'b0;

    crc_result_t awaited_results [$];

    crc64_byte_stream_checker DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // LSB-first fold of one byte, reflected polynomial, bit at a time
    function automatic logic [63:0] fold_in(input logic [63:0] crc, input logic [7:0] b);
        logic [63:0] c;
        c = crc ^ {56'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Advance the predicted state by one accepted byte; returns 1 when a result is due.
    function automatic bit advance_crc_model(input logic [7:0] b, input bit last,
                                             output crc_result_t res);
        logic [63:0] stored;
        res = NONE;
        if (!msg_open) begin
            crc_acc    = ex_start;
            trail_win  = '0;
            trail_fill = '0;
            byte_total = '0;
            msg_open   = 1'b1;
        end
        if (ex_check) begin
            // the byte falling out of the trailer window joins the payload
            if (trail_fill >= 4'd8) begin
                crc_acc = fold_in(crc_acc, trail_win[63:56]);
                if (byte_total != '1) byte_total++;
            end else begin
                trail_fill++;
            end
            trail_win = {trail_win[55:0], b};
        end else begin
            crc_acc = fold_in(crc_acc, b);
            if (byte_total != '1) byte_total++;
        end
        if (!last) return 1'b0;
        msg_open = 1'b0;
        if (!ex_check) begin
            res = '{crc_acc, byte_total, STATUS_COMPUTED};
        end else if (trail_fill < 4'd8) begin
            res = '{64'h0, 32'd0, STATUS_TOO_SHORT};
        end else begin
            // first trailer byte is the oldest: big endian reads the window as is
            stored = {<<8{trail_win}};
            if (ex_big) stored = trail_win;
            res = '{crc_acc, byte_total,
                    (stored == crc_acc) ? STATUS_MATCH : STATUS_MISMATCH};
        end
        return 1'b1;
    endfunction

    // Offer one byte, idling first at random; predict once it is taken.
    task automatic send_byte(input logic [7:0] b, input bit last, input bit use_want,
                             input crc_result_t want);
        crc_result_t res;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        if (advance_crc_model(b, last, res)) awaited_results.push_back(use_want ? want : res);
    endtask

    // Drain: all results in, then give bytes still in the pipe time to land.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [63:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_START_VALUE: ex_start = val;
            CFG_CHECK_MODE:  ex_check = val[0];
            CFG_TRAILER_BIG: ex_big   = val[0];
            default: ;
        endcase
    endtask

    // Random register write; start value leans toward its extremes.
    task automatic shuffle_config();
        cfg_index_t  idx;
        logic [63:0] val;
        idx = cfg_index_t'($urandom_range(3));
        val = {$urandom, $urandom};
        if (idx == CFG_START_VALUE) begin
            case ($urandom_range(3))
                0: val = '0;
                1: val = '1;
                default: ;
            endcase
        end
        write_reg(idx, val);
    endtask

    // One message: in check mode mostly payload plus its correct trailer, some too short;
    // some messages get a flipped bit, a few a register write partway through.
    task automatic send_random_message(output int n_sent);
        logic [7:0]  msg [$];
        logic [63:0] c;
        int          plen;
        int          pos;
        int          split_at;
        plen = ($urandom_range(19) == 0) ? $urandom_range(200) : $urandom_range(12);
        if (ex_check && $urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 7)) msg.push_back(8'($urandom));
        end else if (ex_check) begin
            c = ex_start;
            repeat (plen) begin
                msg.push_back(8'($urandom));
                c = fold_in(c, msg[$]);
            end
            for (int k = 0; k < 8; k++) begin
                msg.push_back(ex_big ? c[8*(7-k) +: 8] : c[8*k +: 8]);
            end
        end else begin
            repeat (plen + 1) msg.push_back(8'($urandom));
        end
        if ($urandom_range(4) == 0) begin
            pos = $urandom_range(msg.size() - 1);
            msg[pos] ^= 8'(1 << $urandom_range(7));
        end
        split_at = -1;
        if (msg.size() > 1 && $urandom_range(39) == 0) split_at = $urandom_range(1, msg.size() - 1);
        foreach (msg[i]) begin
            if (i == split_at) shuffle_config();
            send_byte(msg[i], i == msg.size() - 1, 1'b0, NONE);
        end
        n_sent = msg.size();
    endtask

    // Result side: compare with the oldest expectation, then pick next cycle's ready.
    always @(posedge aclk) begin
        crc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected result: crc_value %h payload_length %0d status %0d",
                       m_tdata[63:0], m_tdata[95:64], m_tuser);
                fail_count++;
            end else begin
                want = awaited_results.pop_front();
                if (m_tdata[63:0] !== want.crc) begin
                    $error("crc_value: expected %h, actual %h", want.crc, m_tdata[63:0]);
                    fail_count++;
                end
                if (m_tdata[95:64] !== want.len) begin
                    $error("payload_length: expected %0d, actual %0d", want.len,
                           m_tdata[95:64]);
                    fail_count++;
                end
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_tuser);
                    fail_count++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int src_pct [NUM_PHASES];
        int sink_pct [NUM_PHASES];
        int sent;
        int n;
        int w;
        // phases: no idling, sender idle, receiver stalling, both
        src_pct  = '{0, 76, 0, 36};
        sink_pct = '{0, 0, 76, 36};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, no idling
        foreach (directed_plan[r]) begin
            if (directed_plan[r].kind == ROW_CFG) begin
                write_reg(directed_plan[r].reg_idx, directed_plan[r].value);
            end else begin
                for (int k = 0; k < directed_plan[r].reps; k++) begin
                    send_byte(directed_plan[r].value[7:0],
                              directed_plan[r].last && (k == directed_plan[r].reps - 1),
                              directed_plan[r].typed, directed_plan[r].want);
                end
            end
        end

        // random part, one idling pattern per phase
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            src_idle_pct   = src_pct[p];
            sink_stall_pct = sink_pct[p];
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(3) == 0) shuffle_config();
                send_random_message(n);
                sent += n;
            end
        end

        // wind down: results in, then a settling wait for stragglers
        s_tvalid <= 1'b0;
        for (w = 0; w < 5000 && awaited_results.size() != 0; w++) @(posedge aclk);
        repeat (2 * SETTLE_CYCLES) @(posedge aclk);
        if (awaited_results.size() != 0) begin
            $error("%0d results never arrived", awaited_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
